// ===== hw/rtl/biou_pkg.sv =====
package biou_pkg;

    localparam int COORD_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 16;

    // front pipeline depth, from accepted beat to queue push
    localparam int FRONT_STAGES = 4;
    localparam int QUEUE_DEPTH  = 8;
    // start-to-strobe latency: front, queue push and pop, one stage per quotient bit
    localparam int LATENCY_EXTRA = FRONT_STAGES + 2;

    typedef struct packed {
        logic empty;
        logic almost_full;
    } t_queue_status;

endpackage

// ===== hw/rtl/biou_front.sv =====
module biou_front #(
    parameter int COORD_BITS = biou_pkg::COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [COORD_BITS-1:0]     i_first_left,
    input  logic [COORD_BITS-1:0]     i_first_top,
    input  logic [COORD_BITS-2:0]     i_first_width,
    input  logic [COORD_BITS-2:0]     i_first_height,
    input  logic [COORD_BITS-1:0]     i_second_left,
    input  logic [COORD_BITS-1:0]     i_second_top,
    input  logic [COORD_BITS-2:0]     i_second_width,
    input  logic [COORD_BITS-2:0]     i_second_height,
    output logic                      o_valid,
    output logic [2*COORD_BITS-3:0]   o_inter,
    output logic [2*COORD_BITS-2:0]   o_union,
    output logic                      o_empty
);
    import biou_pkg::*;

    localparam int CW = COORD_BITS + 1;   // edge coordinate width
    localparam int SW = COORD_BITS - 1;   // size width
    localparam int AW = 2 * COORD_BITS - 2;
    localparam int UW = 2 * COORD_BITS - 1;

    // stage A: overlap bounds
    logic                 r_va;
    logic signed [CW-1:0] r_lft, r_rgt, r_top, r_bot;
    logic [SW-1:0]        r_aw, r_ah, r_bw, r_bh;
    logic signed [CW-1:0] n_ax, n_ay, n_bx, n_by, n_ar, n_ab, n_br, n_bb;

    always_comb begin
        n_ax = $signed({i_first_left[COORD_BITS-1], i_first_left});
        n_ay = $signed({i_first_top[COORD_BITS-1], i_first_top});
        n_bx = $signed({i_second_left[COORD_BITS-1], i_second_left});
        n_by = $signed({i_second_top[COORD_BITS-1], i_second_top});
        n_ar = n_ax + $signed({2'b00, i_first_width});
        n_ab = n_ay + $signed({2'b00, i_first_height});
        n_br = n_bx + $signed({2'b00, i_second_width});
        n_bb = n_by + $signed({2'b00, i_second_height});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else begin
            r_va <= i_valid;
        end
        r_lft <= (n_ax > n_bx) ? n_ax : n_bx;
        r_top <= (n_ay > n_by) ? n_ay : n_by;
        r_rgt <= (n_ar < n_br) ? n_ar : n_br;
        r_bot <= (n_ab < n_bb) ? n_ab : n_bb;
        r_aw  <= i_first_width;
        r_ah  <= i_first_height;
        r_bw  <= i_second_width;
        r_bh  <= i_second_height;
    end

    // stage B: overlap extents, box areas
    logic                 r_vb;
    logic [SW-1:0]        r_iw, r_ih;
    logic [AW-1:0]        r_a1, r_a2;
    logic                 n_disj;
    logic signed [CW-1:0] n_dw, n_dh;

    always_comb begin
        n_disj = (r_top > r_bot) || (r_rgt < r_lft);
        n_dw   = r_rgt - r_lft;
        n_dh   = r_bot - r_top;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else begin
            r_vb <= r_va;
        end
        // extent never exceeds the smaller size when the boxes meet
        r_iw <= n_disj ? '0 : n_dw[SW-1:0];
        r_ih <= n_disj ? '0 : n_dh[SW-1:0];
        r_a1 <= r_aw * r_ah;
        r_a2 <= r_bw * r_bh;
    end

    // stage C: overlap area, area sum
    logic          r_vc;
    logic [AW-1:0] r_inter_c;
    logic [UW-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else begin
            r_vc <= r_vb;
        end
        r_inter_c <= r_iw * r_ih;
        r_sum     <= {1'b0, r_a1} + {1'b0, r_a2};
    end

    // stage D: union area
    logic          r_vd;
    logic [AW-1:0] r_inter_d;
    logic [UW-1:0] r_union;
    logic          r_empty;
    logic [UW-1:0] n_union;

    assign n_union = r_sum - {1'b0, r_inter_c};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
        end else begin
            r_vd <= r_vc;
        end
        r_inter_d <= r_inter_c;
        r_union   <= n_union;
        r_empty   <= (n_union == '0);
    end

    assign o_valid = r_vd;
    assign o_inter = r_inter_d;
    assign o_union = r_union;
    assign o_empty = r_empty;

endmodule

// ===== hw/rtl/biou_queue.sv =====
module biou_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = biou_pkg::QUEUE_DEPTH,
    parameter int AFULL = biou_pkg::QUEUE_DEPTH - biou_pkg::FRONT_STAGES
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic [WIDTH-1:0]        i_data,
    input  logic                    i_pop,
    output logic [WIDTH-1:0]        o_data,
    output biou_pkg::t_queue_status o_status
);
    import biou_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [NW-1:0]    r_count;
    logic             n_push, n_pop;

    assign n_push = i_push && (r_count != NW'(DEPTH));
    assign n_pop  = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (n_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (n_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (n_push && !n_pop) begin
                r_count <= r_count + 1'b1;
            end else if (n_pop && !n_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data               = r_mem[r_rd];
    assign o_status.empty       = (r_count == '0);
    assign o_status.almost_full = (r_count >= NW'(AFULL));

endmodule

// ===== hw/rtl/biou_div.sv =====
module biou_div #(
    parameter int COORD_BITS    = biou_pkg::COORD_BITS_DEF,
    parameter int FRACTION_BITS = biou_pkg::FRACTION_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [2*COORD_BITS-3:0]  i_inter,
    input  logic [2*COORD_BITS-2:0]  i_union,
    input  logic                     i_empty,
    output logic                     o_valid,
    output logic [FRACTION_BITS:0]   o_ratio,
    output logic [2*COORD_BITS-3:0]  o_inter,
    output logic [2*COORD_BITS-2:0]  o_union,
    output logic                     o_empty
);
    import biou_pkg::*;

    localparam int AW = 2 * COORD_BITS - 2;
    localparam int UW = 2 * COORD_BITS - 1;
    localparam int RW = 2 * COORD_BITS;
    localparam int QW = FRACTION_BITS + 1;
    localparam int NS = FRACTION_BITS + 1;

    // one restoring step per quotient bit, MSB first
    logic          r_v     [1:NS];
    logic [RW-1:0] r_rem   [1:NS];
    logic [QW-1:0] r_q     [1:NS];
    logic [UW-1:0] r_d     [1:NS];
    logic [AW-1:0] r_inter [1:NS];
    logic          r_empty [1:NS];

    for (genvar k = 0; k < NS; k++) begin : g_step
        logic          v_in, e_in, ge;
        logic [RW-1:0] trial, n_rem;
        logic [QW-1:0] q_in, n_q;
        logic [UW-1:0] d_in;
        logic [AW-1:0] a_in;

        if (k == 0) begin : g_first
            assign v_in  = i_valid;
            assign e_in  = i_empty;
            assign q_in  = '0;
            assign d_in  = i_union;
            assign a_in  = i_inter;
            assign trial = {2'b00, i_inter};
        end else begin : g_next
            assign v_in  = r_v[k];
            assign e_in  = r_empty[k];
            assign q_in  = r_q[k];
            assign d_in  = r_d[k];
            assign a_in  = r_inter[k];
            assign trial = {r_rem[k][RW-2:0], 1'b0};
        end

        always_comb begin
            ge    = (trial >= {1'b0, d_in});
            n_rem = ge ? (trial - {1'b0, d_in}) : trial;
            n_q   = q_in;
            n_q[FRACTION_BITS-k] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= v_in;
            end
            r_rem[k+1]   <= n_rem;
            r_q[k+1]     <= n_q;
            r_d[k+1]     <= d_in;
            r_inter[k+1] <= a_in;
            r_empty[k+1] <= e_in;
        end
    end

    // zero divisor would give all ones; force zero
    assign o_valid = r_v[NS];
    assign o_ratio = r_empty[NS] ? '0 : r_q[NS];
    assign o_inter = r_inter[NS];
    assign o_union = r_d[NS];
    assign o_empty = r_empty[NS];

endmodule

// ===== hw/rtl/box_intersection_over_union_core.sv =====
// Channel   Handshake                   Beat contents
// --------  --------------------------  ------------------------------------------------
// request   start & !busy at the edge   i_first_*/i_second_* : left, top, width, height
// result    o_result_valid, one cycle   o_overlap_ratio, o_overlap_area, o_union_area,
//                                       o_empty_union
//
// One box pair per cycle while busy is low. Each result passes through four front
// stages, one queue push and pop, and one divider stage per quotient bit
// (FRACTION_BITS + 1 restoring steps).
// Synchronous active-low reset clears all valid bits and the queue pointers.
// The result side cannot stall; busy rises only if the queue nears full, which a
// divider draining one beat per cycle never lets happen in steady use.
module box_intersection_over_union_core #(
    parameter int COORD_BITS    = biou_pkg::COORD_BITS_DEF,
    parameter int FRACTION_BITS = biou_pkg::FRACTION_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [COORD_BITS-1:0]    i_first_left,
    input  logic [COORD_BITS-1:0]    i_first_top,
    input  logic [COORD_BITS-2:0]    i_first_width,
    input  logic [COORD_BITS-2:0]    i_first_height,
    input  logic [COORD_BITS-1:0]    i_second_left,
    input  logic [COORD_BITS-1:0]    i_second_top,
    input  logic [COORD_BITS-2:0]    i_second_width,
    input  logic [COORD_BITS-2:0]    i_second_height,
    output logic                     o_result_valid,
    output logic [FRACTION_BITS:0]   o_overlap_ratio,
    output logic [2*COORD_BITS-3:0]  o_overlap_area,
    output logic [2*COORD_BITS-2:0]  o_union_area,
    output logic                     o_empty_union
);
    import biou_pkg::*;

    localparam int AW = 2 * COORD_BITS - 2;
    localparam int UW = 2 * COORD_BITS - 1;
    localparam int EW = AW + UW + 1;   // queue entry: overlap, union, empty flag

    logic          accept;
    logic          f_valid, f_empty;
    logic [AW-1:0] f_inter;
    logic [UW-1:0] f_union;
    logic [EW-1:0] q_head;
    t_queue_status q_status;
    logic          pop;

    // busy covers beats still in the front stages
    assign busy   = q_status.almost_full;
    assign accept = start && !busy;

    biou_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (accept),
        .i_first_left   (i_first_left),
        .i_first_top    (i_first_top),
        .i_first_width  (i_first_width),
        .i_first_height (i_first_height),
        .i_second_left  (i_second_left),
        .i_second_top   (i_second_top),
        .i_second_width (i_second_width),
        .i_second_height(i_second_height),
        .o_valid        (f_valid),
        .o_inter        (f_inter),
        .o_union        (f_union),
        .o_empty        (f_empty)
    );

    biou_queue #(
        .WIDTH(EW),
        .DEPTH(QUEUE_DEPTH),
        .AFULL(QUEUE_DEPTH - FRONT_STAGES)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  ({f_inter, f_union, f_empty}),
        .i_pop   (pop),
        .o_data  (q_head),
        .o_status(q_status)
    );

    // divider pipeline never stalls: take the head whenever there is one
    assign pop = !q_status.empty;

    biou_div #(
        .COORD_BITS   (COORD_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pop),
        .i_inter (q_head[EW-1 -: AW]),
        .i_union (q_head[UW:1]),
        .i_empty (q_head[0]),
        .o_valid (o_result_valid),
        .o_ratio (o_overlap_ratio),
        .o_inter (o_overlap_area),
        .o_union (o_union_area),
        .o_empty (o_empty_union)
    );

endmodule

// ===== hw/rtl/biou_checker.sv =====
module biou_checker #(
    parameter int COORD_BITS    = biou_pkg::COORD_BITS_DEF,
    parameter int FRACTION_BITS = biou_pkg::FRACTION_BITS_DEF
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     o_result_valid,
    input logic [FRACTION_BITS:0]   o_overlap_ratio,
    input logic [2*COORD_BITS-3:0]  o_overlap_area,
    input logic [2*COORD_BITS-2:0]  o_union_area,
    input logic                     o_empty_union
);
    import biou_pkg::*;

    localparam int LAT = FRACTION_BITS + LATENCY_EXTRA;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_result_valid)
        else $error("accepted beat gave no result at fixed latency");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_empty_union == (o_union_area == '0)))
        else $error("empty flag disagrees with union area");

    a_empty_ratio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_empty_union) |-> (o_overlap_ratio == '0))
        else $error("ratio not zero on empty union");

    a_ratio_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_overlap_ratio <= (FRACTION_BITS+1)'(1 << FRACTION_BITS)))
        else $error("ratio above one");

    a_area_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ({1'b0, o_overlap_area} <= o_union_area))
        else $error("overlap area exceeds union area");

endmodule

bind box_intersection_over_union_core biou_checker #(
    .COORD_BITS   (COORD_BITS),
    .FRACTION_BITS(FRACTION_BITS)
) u_biou_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_overlap_ratio(o_overlap_ratio),
    .o_overlap_area (o_overlap_area),
    .o_union_area   (o_union_area),
    .o_empty_union  (o_empty_union)
);

// ===== dv/box_intersection_over_union_core_test.sv =====
`timescale 1ns / 100ps

module box_intersection_over_union_core_test;

    localparam int CB = biou_pkg::COORD_BITS_DEF;
    localparam int FB = biou_pkg::FRACTION_BITS_DEF;
    // start-to-strobe latency, as the bound checker assumes it
    localparam int PIPE_CYCLES = FB + biou_pkg::LATENCY_EXTRA;
    // cycles with neither a request nor a result beat before we give up
    localparam int STALL_LIMIT = 4000;
    localparam int SIZE_MAX = (1 << (CB - 1)) - 1;
    localparam int COORD_MIN = -(1 << (CB - 1));
    localparam int COORD_MAX = (1 << (CB - 1)) - 1;

    typedef struct packed {
        logic signed [CB-1:0] left;
        logic signed [CB-1:0] top;
        logic [CB-2:0]        width;
        logic [CB-2:0]        height;
    } t_box;

    typedef struct packed {
        t_box first;
        t_box second;
    } t_box_pair;

    typedef struct packed {
        logic [FB:0]     ratio;
        logic [2*CB-3:0] overlap_area;
        logic [2*CB-2:0] union_area;
        logic            empty_union;
    } t_iou_result;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [CB-1:0]       i_first_left = '0;
    logic [CB-1:0]       i_first_top = '0;
    logic [CB-2:0]       i_first_width = '0;
    logic [CB-2:0]       i_first_height = '0;
    logic [CB-1:0]       i_second_left = '0;
    logic [CB-1:0]       i_second_top = '0;
    logic [CB-2:0]       i_second_width = '0;
    logic [CB-2:0]       i_second_height = '0;
    logic                o_result_valid;
    logic [FB:0]         o_overlap_ratio;
    logic [2*CB-3:0]     o_overlap_area;
    logic [2*CB-2:0]     o_union_area;
    logic                o_empty_union;

    // IoU results owed by the core, oldest first
    t_iou_result pending_iou[$];

    int error_count = 0;
    int pairs_sent = 0;
    int results_seen = 0;
    int zero_overlap_seen = 0;
    int empty_union_seen = 0;
    int exact_match_seen = 0;
    int stall_cycles = 0;

    // sender burst shaping: gaps_on == 0 gives a stretch of back-to-back beats
    bit gaps_on = 1'b1;
    int burst_left = 0;

    box_intersection_over_union_core #(
        .COORD_BITS    (CB),
        .FRACTION_BITS (FB)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_first_left    (i_first_left),
        .i_first_top     (i_first_top),
        .i_first_width   (i_first_width),
        .i_first_height  (i_first_height),
        .i_second_left   (i_second_left),
        .i_second_top    (i_second_top),
        .i_second_width  (i_second_width),
        .i_second_height (i_second_height),
        .o_result_valid  (o_result_valid),
        .o_overlap_ratio (o_overlap_ratio),
        .o_overlap_area  (o_overlap_area),
        .o_union_area    (o_union_area),
        .o_empty_union   (o_empty_union)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor: overlap bounds from max/min of the edges, union as the
    // sum of areas minus overlap, ratio = (overlap << FB) / union, floored.
    // Edges are widened to 64 bits so left + width never wraps.
    // ------------------------------------------------------------------
    function automatic t_iou_result predict_iou(t_box_pair p);
        longint ax, ay, aw, ah, bx, by, bw, bh;
        longint y_lo, y_hi, x_lo, x_hi, inter, uni, ratio;
        bit disjoint;
        t_iou_result r;
        ax = longint'(p.first.left);
        ay = longint'(p.first.top);
        aw = longint'(p.first.width);
        ah = longint'(p.first.height);
        bx = longint'(p.second.left);
        by = longint'(p.second.top);
        bw = longint'(p.second.width);
        bh = longint'(p.second.height);
        y_lo = (ay > by) ? ay : by;
        y_hi = (ay + ah < by + bh) ? ay + ah : by + bh;
        x_lo = (ax > bx) ? ax : bx;
        x_hi = (ax + aw < bx + bw) ? ax + aw : bx + bw;
        // touching edges are not disjoint, they just give zero area
        disjoint = (y_lo > y_hi) || (x_hi < x_lo);
        inter = disjoint ? 64'sd0 : (x_hi - x_lo) * (y_hi - y_lo);
        uni = aw * ah + bw * bh - inter;
        // zero union: no divide, ratio forced to zero and flagged
        ratio = (!disjoint && uni != 0) ? (inter <<< FB) / uni : 64'sd0;
        r.ratio = ratio[FB:0];
        r.overlap_area = inter[2*CB-3:0];
        r.union_area = uni[2*CB-2:0];
        r.empty_union = (uni == 0);
        return r;
    endfunction

    function automatic t_box make_box(int left, int top, int width, int height);
        t_box b;
        b.left = left[CB-1:0];
        b.top = top[CB-1:0];
        b.width = width[CB-2:0];
        b.height = height[CB-2:0];
        return b;
    endfunction

    // mostly small boxes, with the empty and the largest sizes mixed in
    function automatic int rand_size();
        case ($urandom_range(9))
            0: return 0;
            1: return SIZE_MAX;
            2, 3: return $urandom_range(SIZE_MAX);
            default: return $urandom_range(300);
        endcase
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(7))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2, 3: return int'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
            default: return int'($urandom_range(2000)) - 1000;
        endcase
    endfunction

    function automatic int clamp_coord(int v);
        if (v < COORD_MIN) return COORD_MIN;
        if (v > COORD_MAX) return COORD_MAX;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Sender. Fields and start move only by NBA at a rising edge. A beat
    // lands at the first edge with start high and busy low. start stays
    // high across a burst and is only lowered by idle_for / wait_drained.
    // ------------------------------------------------------------------
    task automatic idle_for(int cycles);
        start <= 1'b0;
        // garbage on the fields while start is low must be ignored
        i_first_left <= CB'($urandom);
        i_first_top <= CB'($urandom);
        i_first_width <= (CB-1)'($urandom);
        i_first_height <= (CB-1)'($urandom);
        i_second_left <= CB'($urandom);
        i_second_top <= CB'($urandom);
        i_second_width <= (CB-1)'($urandom);
        i_second_height <= (CB-1)'($urandom);
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic send_pair(t_box_pair p);
        t_iou_result exp_r;
        if (gaps_on && burst_left == 0) begin
            // gap lengths straddle the pipeline depth so idles hit every stage
            idle_for($urandom_range(1, PIPE_CYCLES + 8));
            burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        start <= 1'b1;
        i_first_left <= p.first.left;
        i_first_top <= p.first.top;
        i_first_width <= p.first.width;
        i_first_height <= p.first.height;
        i_second_left <= p.second.left;
        i_second_top <= p.second.top;
        i_second_width <= p.second.width;
        i_second_height <= p.second.height;
        do @(posedge i_clk); while (busy !== 1'b0);
        exp_r = predict_iou(p);
        pending_iou = {pending_iou, exp_r};
        pairs_sent++;
        if (exp_r.overlap_area == 0) zero_overlap_seen++;
        if (exp_r.empty_union) empty_union_seen++;
        if (exp_r.ratio == (FB+1)'(1 << FB)) exact_match_seen++;
    endtask

    task automatic send_boxes(int al, int at, int aw, int ah,
                              int bl, int bt, int bw, int bh);
        t_box_pair p;
        p.first = make_box(al, at, aw, ah);
        p.second = make_box(bl, bt, bw, bh);
        send_pair(p);
    endtask

    // sender holds off until every owed result has come back
    task automatic wait_drained();
        start <= 1'b0;
        while (pending_iou.size() != 0) @(posedge i_clk);
        burst_left = 0;
    endtask

    // ------------------------------------------------------------------
    // Result checker: a strobe is one beat, consumed at the edge that
    // ends its cycle; compared field by field against the oldest entry.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_iou_result exp_r;
        if (i_rst_n) begin
            if ($isunknown(o_result_valid)) begin
                $display("%0t: result strobe unknown: expected 0/1, got %b",
                         $time, o_result_valid);
                error_count++;
            end else if (o_result_valid) begin
                results_seen++;
                if (pending_iou.size() == 0) begin
                    $display("%0t: unexpected result beat: expected none, got ratio %0d",
                             $time, o_overlap_ratio);
                    error_count++;
                end else begin
                    exp_r = pending_iou.pop_front();
                    if (o_overlap_ratio !== exp_r.ratio) begin
                        $display("%0t: overlap_ratio: expected %0d, got %0d",
                                 $time, exp_r.ratio, o_overlap_ratio);
                        error_count++;
                    end
                    if (o_overlap_area !== exp_r.overlap_area) begin
                        $display("%0t: overlap_area: expected %0d, got %0d",
                                 $time, exp_r.overlap_area, o_overlap_area);
                        error_count++;
                    end
                    if (o_union_area !== exp_r.union_area) begin
                        $display("%0t: union_area: expected %0d, got %0d",
                                 $time, exp_r.union_area, o_union_area);
                        error_count++;
                    end
                    if (o_empty_union !== exp_r.empty_union) begin
                        $display("%0t: empty_union: expected %0d, got %0d",
                                 $time, exp_r.empty_union, o_empty_union);
                        error_count++;
                    end
                end
            end
        end
    end

    // watchdog: any request or result beat resets the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_result_valid === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat for %0d cycles, %0d results still owed",
                         $time, STALL_LIMIT, pending_iou.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // identical, nested and partly overlapping boxes, incl. negative coords
    task automatic test_overlap_shapes();
        send_boxes(0, 0, 100, 100, 0, 0, 100, 100);
        send_boxes(0, 0, 100, 100, 25, 25, 50, 50);
        send_boxes(0, 0, 100, 100, 50, 50, 100, 100);
        send_boxes(-50, -70, 80, 30, -20, -60, 10, 100);
        send_boxes(-1, -1, 3, 3, 0, 0, 1, 1);
        // zero-width sliver inside a box: no overlap area, union = big box
        send_boxes(0, 0, 100, 100, 40, 10, 0, 50);
    endtask

    // boxes apart in x, apart in y, and sharing only an edge or a corner
    task automatic test_disjoint_and_touching();
        send_boxes(0, 0, 10, 10, 20, 0, 10, 10);
        send_boxes(0, 0, 10, 10, 0, -30, 10, 10);
        send_boxes(0, 0, 10, 10, 10, 0, 10, 10);
        send_boxes(0, 0, 10, 10, 0, 10, 10, 10);
        send_boxes(0, 0, 10, 10, 10, 10, 5, 5);
    endtask

    // both areas zero: no divide, flag raised, also when points are apart
    task automatic test_empty_union();
        send_boxes(5, 5, 0, 0, 5, 5, 0, 0);
        send_boxes(-100, 7, 0, 9, 300, -2, 4, 0);
        send_boxes(COORD_MIN, COORD_MAX, 0, SIZE_MAX, COORD_MAX, COORD_MIN, SIZE_MAX, 0);
    endtask

    // corner and size extremes: largest areas, largest union, far edges
    task automatic test_field_extremes();
        send_boxes(COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX,
                   COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX);
        send_boxes(COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX,
                   COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX);
        send_boxes(COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX,
                   COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX);
        send_boxes(COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX, 0, 0, 1, 1);
        send_boxes(-1, -1, SIZE_MAX, 1, -1, -1, 1, SIZE_MAX);
        send_boxes(COORD_MAX, COORD_MIN, SIZE_MAX, SIZE_MAX,
                   -1, -1, SIZE_MAX, SIZE_MAX);
    endtask

    // well-formed pairs: second box placed so the two mostly overlap
    task automatic test_random_overlap(int count);
        t_box_pair p;
        int aw, ah, bw, bh, ax, ay;
        for (int n = 0; n < count; n++) begin
            ax = rand_coord();
            ay = rand_coord();
            aw = rand_size();
            ah = rand_size();
            p.first = make_box(ax, ay, aw, ah);
            case ($urandom_range(9))
                0: p.second = p.first;
                1: begin
                    bw = $urandom_range(aw);
                    bh = $urandom_range(ah);
                    p.second = make_box(clamp_coord(ax + int'($urandom_range(aw - bw))),
                                        clamp_coord(ay + int'($urandom_range(ah - bh))),
                                        bw, bh);
                end
                default: begin
                    bw = rand_size();
                    bh = rand_size();
                    p.second = make_box(clamp_coord(ax + int'($urandom_range(aw + bw)) - bw),
                                        clamp_coord(ay + int'($urandom_range(ah + bh)) - bh),
                                        bw, bh);
                end
            endcase
            if ($urandom_range(1)) begin
                t_box t;
                t = p.first;
                p.first = p.second;
                p.second = t;
            end
            send_pair(p);
            // let the pipe run dry once mid-stream
            if (n == count / 2) wait_drained();
        end
    endtask

    // raw random bits on every field: mostly disjoint, covers every bit
    task automatic test_random_noise(int count);
        t_box_pair p;
        logic [127:0] noise;
        for (int n = 0; n < count; n++) begin
            noise = {$urandom, $urandom, $urandom, $urandom};
            p = noise[$bits(t_box_pair)-1:0];
            send_pair(p);
        end
    endtask

    // long run of back-to-back beats, then drain
    task automatic test_back_to_back(int count);
        t_box_pair p;
        gaps_on = 1'b0;
        for (int n = 0; n < count; n++) begin
            p.first = make_box(rand_coord(), rand_coord(), rand_size(), rand_size());
            p.second = ($urandom_range(2) == 0)
                ? make_box(rand_coord(), rand_coord(), rand_size(), rand_size())
                : p.first;
            if (p.second == p.first) p.second.width = (CB-1)'(rand_size());
            send_pair(p);
        end
        wait_drained();
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_overlap_shapes();
        test_disjoint_and_touching();
        test_empty_union();
        test_field_extremes();
        wait_drained();
        test_random_overlap(1000);
        test_random_noise(450);
        test_back_to_back(250);

        // nothing owed; wait out the pipeline for stray beats
        wait_drained();
        repeat (PIPE_CYCLES + 10) @(posedge i_clk);

        $display("Run covered %0d box pairs and %0d result beats with bursty and",
                 pairs_sent, results_seen);
        $display("back-to-back requests: %0d zero-overlap, %0d empty-union, %0d exact-match.",
                 zero_overlap_seen, empty_union_seen, exact_match_seen);
        if (error_count == 0 && pending_iou.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     error_count, pending_iou.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/biou_pkg.sv
hw/rtl/biou_front.sv
hw/rtl/biou_queue.sv
hw/rtl/biou_div.sv
hw/rtl/box_intersection_over_union_core.sv
hw/rtl/biou_checker.sv
dv/box_intersection_over_union_core_test.sv
